### rtl/core/byte_stream_substring_finder_macros.svh
// Assertion macros used by the top-level RTL.
`ifndef BYTE_STREAM_SUBSTRING_FINDER_MACROS_SVH
`define BYTE_STREAM_SUBSTRING_FINDER_MACROS_SVH

// Same-cycle implication under reset.
`define BSF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under reset.
`define BSF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/bsf_pkg.sv
`default_nettype none

package bsf_pkg;

    localparam int PATTERN_BYTES = 16;
    localparam int LEN_W         = 5;
    localparam int OFFSET_W      = 16;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 64;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PATTERN_LOW    = 2'd0,
        REG_PATTERN_HIGH   = 2'd1,
        REG_PATTERN_LEN    = 2'd2,
        REG_CASE_SENSITIVE = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [PATTERN_BYTES-1:0][7:0] pattern;
        logic [LEN_W-1:0]              len;
        logic                          fold;
    } cfg_t;

    function automatic logic [7:0] fold_byte(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
        begin
            r = c - CHAR_UPPER_A + CHAR_LOWER_A;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/core/bsf_cfg_regs.sv
`default_nettype none

module bsf_cfg_regs #(
    parameter int PATTERN_MAX = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            wr_en,
    input  wire logic [bsf_pkg::CFG_INDEX_W-1:0] wr_index,
    input  wire logic [bsf_pkg::CFG_DATA_W-1:0]  wr_data,
    output bsf_pkg::cfg_t                        cfg
);
    import bsf_pkg::*;

    logic [63:0]      pattern_low_reg;
    logic [63:0]      pattern_high_reg;
    logic [LEN_W-1:0] pattern_len_reg;
    logic             case_sensitive_reg;
    logic [127:0]     pattern_all;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            pattern_len_reg    <= LEN_W'(1);
            case_sensitive_reg <= 1'b1;
        end
        else if (wr_en)
        begin
            case (cfg_reg_t'(wr_index))
                REG_PATTERN_LOW:    pattern_low_reg    <= wr_data;
                REG_PATTERN_HIGH:   pattern_high_reg   <= wr_data;
                REG_PATTERN_LEN:    pattern_len_reg    <= wr_data[LEN_W-1:0];
                REG_CASE_SENSITIVE: case_sensitive_reg <= wr_data[0];
                default:            ;
            endcase
        end
    end

    assign pattern_all = {pattern_high_reg, pattern_low_reg};

    // fold the pattern once; clamp the length into range
    always_comb
    begin
        cfg.fold = !case_sensitive_reg;
        for (int k = 0; k < PATTERN_BYTES; k++)
        begin
            cfg.pattern[k] = case_sensitive_reg ? pattern_all[8*k +: 8]
                                                : fold_byte(pattern_all[8*k +: 8]);
        end
        if (pattern_len_reg == '0)
        begin
            cfg.len = LEN_W'(1);
        end
        else if (pattern_len_reg > LEN_W'(PATTERN_MAX))
        begin
            cfg.len = LEN_W'(PATTERN_MAX);
        end
        else
        begin
            cfg.len = pattern_len_reg;
        end
    end

endmodule

`default_nettype wire

### rtl/core/bsf_matcher.sv
`default_nettype none

module bsf_matcher #(
    parameter int PATTERN_MAX = 16
) (
    input  wire logic [PATTERN_MAX-1:0][7:0] window,
    input  wire bsf_pkg::cfg_t               cfg,
    output logic                             match
);
    import bsf_pkg::*;

    logic [PATTERN_MAX-1:0][7:0] window_cmp;
    logic [PATTERN_MAX-1:0]      hit_len;

    // window[0] is the newest byte; pattern byte 0 is the oldest of the run
    always_comb
    begin
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            window_cmp[i] = cfg.fold ? fold_byte(window[i]) : window[i];
        end
        for (int l = 1; l <= PATTERN_MAX; l++)
        begin
            hit_len[l-1] = 1'b1;
            for (int i = 0; i < l; i++)
            begin
                if (window_cmp[i] != cfg.pattern[l-1-i])
                begin
                    hit_len[l-1] = 1'b0;
                end
            end
        end
        match = 1'b0;
        for (int l = 1; l <= PATTERN_MAX; l++)
        begin
            if (cfg.len == LEN_W'(l))
            begin
                match = hit_len[l-1];
            end
        end
    end

endmodule

`default_nettype wire

### rtl/core/byte_stream_substring_finder.sv
// Channel  Dir  Handshake                  Fields
// byte     in   byte_valid / byte_stall    buffer_byte, last_byte
// result   out  result_valid / result_stall found, match_offset
// cfg      in   cfg_valid / cfg_ready      cfg_index, cfg_data
//
// One byte per cycle unless result_stall holds a full result register; a byte's result is
// registered after its input register. Window, byte count and found mark update together.
// rst_n clears the control and config registers to defaults and starts an empty buffer.
// result_stall holds the result register; byte_stall rises only while a byte
// waits in the input register behind a full, stalled result register.
`default_nettype none
`include "byte_stream_substring_finder_macros.svh"

module byte_stream_substring_finder #(
    parameter int PATTERN_MAX = 16,
    parameter int BUFFER_MAX  = 65536
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            byte_valid,
    output logic                                 byte_stall,
    input  wire logic [7:0]                      buffer_byte,
    input  wire logic                            last_byte,
    output logic                                 result_valid,
    input  wire logic                            result_stall,
    output logic                                 found,
    output logic [bsf_pkg::OFFSET_W-1:0]         match_offset,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [bsf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [bsf_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import bsf_pkg::*;

    localparam int CNT_W = $clog2(BUFFER_MAX + 1);

    cfg_t                        cfg;
    logic                        in_valid_reg;
    logic                        in_valid_next;
    logic [7:0]                  in_byte_reg;
    logic                        in_last_reg;
    logic [PATTERN_MAX-1:0][7:0] window_reg;
    logic [PATTERN_MAX-1:0][7:0] window_next;
    logic [CNT_W-1:0]            seen_reg;
    logic [CNT_W-1:0]            seen_next;
    logic [CNT_W-1:0]            seen_inc;
    logic                        reported_reg;
    logic                        reported_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic                        found_reg;
    logic [OFFSET_W-1:0]         offset_reg;
    logic                        advance;
    logic                        load_in;
    logic                        active;
    logic                        match;
    logic                        hit;
    logic                        emit;
    logic [OFFSET_W-1:0]         offset_calc;

    assign cfg_ready = 1'b1;

    bsf_cfg_regs #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    bsf_matcher #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_match (
        .window (window_next),
        .cfg    (cfg),
        .match  (match)
    );

    assign advance    = in_valid_reg && (!out_valid_reg || !result_stall);
    assign byte_stall = in_valid_reg && !advance;
    assign load_in    = byte_valid && !byte_stall;

    always_comb
    begin
        active   = !reported_reg && (seen_reg < CNT_W'(BUFFER_MAX));
        seen_inc = seen_reg + CNT_W'(1);
        window_next[0] = in_byte_reg;
        for (int i = 1; i < PATTERN_MAX; i++)
        begin
            window_next[i] = window_reg[i-1];
        end
        hit         = active && match && (seen_inc >= CNT_W'(cfg.len));
        emit        = hit || (in_last_reg && !reported_reg);
        offset_calc = OFFSET_W'(seen_inc - CNT_W'(cfg.len));

        in_valid_next = in_valid_reg;
        if (advance)
        begin
            in_valid_next = 1'b0;
        end
        if (load_in)
        begin
            in_valid_next = 1'b1;
        end

        seen_next     = seen_reg;
        reported_next = reported_reg;
        if (advance)
        begin
            if (in_last_reg)
            begin
                seen_next     = '0;
                reported_next = 1'b0;
            end
            else if (active)
            begin
                seen_next     = seen_inc;
                reported_next = hit;
            end
        end

        out_valid_next = out_valid_reg;
        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (advance && emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            seen_reg      <= '0;
            reported_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            seen_reg      <= seen_next;
            reported_reg  <= reported_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_in)
        begin
            in_byte_reg <= buffer_byte;
            in_last_reg <= last_byte;
        end
        if (advance && active)
        begin
            window_reg <= window_next;
        end
        if (advance && emit)
        begin
            found_reg  <= hit;
            offset_reg <= hit ? offset_calc : '0;
        end
    end

    assign result_valid = out_valid_reg;
    assign found        = found_reg;
    assign match_offset = offset_reg;

    `BSF_ASSERT_NOW(a_stall_cause, clk, rst_n, byte_stall,
        in_valid_reg && out_valid_reg && result_stall, "byte_stall without full stalled result")
    `BSF_ASSERT_NEXT(a_buffer_end, clk, rst_n, advance && in_last_reg,
        seen_reg == '0 && !reported_reg, "buffer state not cleared after last byte")
    `BSF_ASSERT_NEXT(a_hit_result, clk, rst_n, advance && hit,
        out_valid_reg && found_reg, "match did not reach the result register")
    `BSF_ASSERT_NOW(a_reported_count, clk, rst_n, reported_reg,
        seen_reg != '0, "found mark set with empty byte count")

endmodule

`default_nettype wire

### tb/tb_byte_stream_substring_finder.sv
module tb_byte_stream_substring_finder;
    timeunit 1ns;
    timeprecision 1ps;

    import bsf_pkg::*;

    localparam int BUFFER_MAX      = 65536;
    localparam int RANDOM_ITEMS    = 1620;
    localparam int PHASE_ITEMS     = 60;
    localparam int DRAIN_CYCLES    = 8;
    localparam int QUIET_LIMIT     = 2000;
    localparam int PRESSURE_CYCLES = 300;

    typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;
    typedef enum logic [1:0] {CHK_MODEL, CHK_NO_RESULT, CHK_RESULT} check_t;

    typedef struct packed {
        row_kind_t            kind;
        cfg_reg_t             idx;
        logic [63:0]          data;
        logic [7:0]           value;
        logic                 last;
        check_t               chk;
        logic                 t_found;
        logic [OFFSET_W-1:0]  t_offset;
    } stim_row_t;

    typedef struct packed {
        logic                found;
        logic [OFFSET_W-1:0] offset;
    } match_t;

    localparam stim_row_t DIRECTED [0:22] = '{
        '{ROW_BYTE, REG_PATTERN_LOW,    64'h0,     8'h00, 1'b0, CHK_RESULT,    1'b1, 16'd0},
        '{ROW_BYTE, REG_PATTERN_LOW,    64'h0,     8'hFF, 1'b1, CHK_NO_RESULT, 1'b0, 16'd0},
        '{ROW_BYTE, REG_PATTERN_LOW,    64'h0,     8'h01, 1'b1, CHK_RESULT,    1'b0, 16'd0},
        '{ROW_BYTE, REG_PATTERN_LOW,    64'h0,     8'hFF, 1'b1, CHK_RESULT,    1'b0, 16'd0},
        '{ROW_CFG,  REG_PATTERN_LOW,    64'h7A4261, 8'h00, 1'b0, CHK_MODEL,    1'b0, 16'd0},
        '{ROW_CFG,  REG_PATTERN_HIGH,   '1,        8'h00, 1'b0, CHK_MODEL,     1'b0, 16'd0},
        '{ROW_CFG,  REG_PATTERN_LEN,    64'd3,     8'h00, 1'b0, CHK_MODEL,     1'b0, 16'd0},
        '{ROW_CFG,  REG_CASE_SENSITIVE, 64'd0,     8'h00, 1'b0, CHK_MODEL,     1'b0, 16'd0},
        '{ROW_BYTE, REG_PATTERN_LOW,    64'h0,     8'h78, 1'b0, CHK_MODEL,     1'b0, 16'd0},
        '{ROW_BYTE, REG_PATTERN_LOW,    64'h0,     8'h41, 1'b0, CHK_MODEL,     1'b0, 16'd0},
        '{ROW_BYTE, REG_PATTERN_LOW,    64'h0,     8'h62, 1'b0, CHK_MODEL,     1'b0, 16'd0},
        '{ROW_BYTE, REG_PATTERN_LOW,    64'h0,     8'h5A, 1'b0, CHK_MODEL,     1'b0, 16'd0},
        '{ROW_BYTE, REG_PATTERN_LOW,    64'h0,     8'h40, 1'b0, CHK_MODEL,     1'b0, 16'd0},
        '{ROW_BYTE, REG_PATTERN_LOW,    64'h0,     8'h5B, 1'b1, CHK_MODEL,     1'b0, 16'd0},
        '{ROW_BYTE, REG_PATTERN_LOW,    64'h0,     8'h60, 1'b0, CHK_MODEL,     1'b0, 16'd0},
        '{ROW_BYTE, REG_PATTERN_LOW,    64'h0,     8'h7B, 1'b0, CHK_MODEL,     1'b0, 16'd0},
        '{ROW_BYTE, REG_PATTERN_LOW,    64'h0,     8'h61, 1'b0, CHK_MODEL,     1'b0, 16'd0},
        '{ROW_BYTE, REG_PATTERN_LOW,    64'h0,     8'h42, 1'b0, CHK_MODEL,     1'b0, 16'd0},
        '{ROW_BYTE, REG_PATTERN_LOW,    64'h0,     8'h7B, 1'b1, CHK_MODEL,     1'b0, 16'd0},
        '{ROW_CFG,  REG_PATTERN_LEN,    64'd0,     8'h00, 1'b0, CHK_MODEL,     1'b0, 16'd0},
        '{ROW_CFG,  REG_CASE_SENSITIVE, 64'd1,     8'h00, 1'b0, CHK_MODEL,     1'b0, 16'd0},
        '{ROW_BYTE, REG_PATTERN_LOW,    64'h0,     8'h41, 1'b0, CHK_MODEL,     1'b0, 16'd0},
        '{ROW_BYTE, REG_PATTERN_LOW,    64'h0,     8'h61, 1'b1, CHK_MODEL,     1'b0, 16'd0}
    };

    localparam logic [7:0] EDGE_BYTES [0:9] = '{
        8'h00, 8'hFF, 8'h40, 8'h5B, 8'h60, 8'h7B,
        CHAR_UPPER_A, CHAR_UPPER_Z, CHAR_LOWER_A, CHAR_LOWER_Z
    };

    logic                   clk;
    logic                   rst_n;
    logic                   byte_valid;
    logic                   byte_stall;
    logic [7:0]             buffer_byte;
    logic                   last_byte;
    logic                   result_valid;
    logic                   result_stall;
    logic                   found;
    logic [OFFSET_W-1:0]    match_offset;
    logic                   cfg_valid;
    logic                   cfg_ready;
    cfg_reg_t               cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    logic [127:0]           pattern_q;
    logic [LEN_W-1:0]       len_q;
    logic                   exact_q;
    logic [7:0]             window_q [16];
    int unsigned            seen_count;
    bit                     reported_q;

    match_t                 pending_matches [$];
    int                     mismatch_count;
    int                     quiet_cycles;
    int                     tx_max_gap;
    int                     rx_max_stall;
    bit                     pressure_req;

    byte_stream_substring_finder #(
        .PATTERN_MAX (16),
        .BUFFER_MAX  (BUFFER_MAX)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .buffer_byte  (buffer_byte),
        .last_byte    (last_byte),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .found        (found),
        .match_offset (match_offset),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bit is_letter(input logic [7:0] c);
        return (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ||
               (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z);
    endfunction

    function automatic logic [7:0] lower_ascii(input logic [7:0] c);
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
        begin
            return c | 8'h20;
        end
        return c;
    endfunction

    function automatic logic [7:0] flip_case(input logic [7:0] c);
        return is_letter(c) ? (c ^ 8'h20) : c;
    endfunction

    function automatic int active_pattern_len();
        int n;
        n = len_q;
        if (n < 1)
        begin
            n = 1;
        end
        if (n > PATTERN_BYTES)
        begin
            n = PATTERN_BYTES;
        end
        return n;
    endfunction

    function automatic void clear_search();
        foreach (window_q[k])
        begin
            window_q[k] = 8'h00;
        end
        seen_count = 0;
        reported_q = 1'b0;
    endfunction

    // shift one byte into the window while the search is active and work out the result it causes, if any
    function automatic void advance_search(input logic [7:0] value, input logic last,
                                           output bit has, output match_t res);
        int         n;
        logic [7:0] a;
        logic [7:0] p;
        bit         hit;
        has = 1'b0;
        res = '0;
        if (!reported_q && seen_count < BUFFER_MAX)
        begin
            n = active_pattern_len();
            for (int k = 15; k > 0; k--)
            begin
                window_q[k] = window_q[k-1];
            end
            window_q[0] = value;
            seen_count++;
            if (seen_count >= n)
            begin
                hit = 1'b1;
                for (int k = 0; k < n; k++)
                begin
                    a = window_q[n-1-k];
                    p = pattern_q[8*k +: 8];
                    if (!exact_q)
                    begin
                        a = lower_ascii(a);
                        p = lower_ascii(p);
                    end
                    if (a != p)
                    begin
                        hit = 1'b0;
                    end
                end
                if (hit)
                begin
                    has = 1'b1;
                    res.found = 1'b1;
                    res.offset = OFFSET_W'(seen_count - n);
                    reported_q = 1'b1;
                end
            end
        end
        if (last)
        begin
            if (!reported_q)
            begin
                has = 1'b1;
                res.found = 1'b0;
                res.offset = '0;
            end
            clear_search();
        end
    endfunction

    function automatic logic [7:0] filler_byte(input int n);
        logic [7:0] c;
        case ($urandom_range(3, 0))
            0, 1:
            begin
                c = pattern_q[8*$urandom_range(n-1, 0) +: 8];
                if ($urandom_range(1, 0) == 1)
                begin
                    c = flip_case(c);
                end
            end
            2:       c = 8'($urandom_range(255, 0));
            default: c = EDGE_BYTES[$urandom_range(9, 0)];
        endcase
        return c;
    endfunction

    function automatic logic [7:0] pattern_pick();
        case ($urandom_range(2, 0))
            0:       return ($urandom_range(1, 0) == 1 ? CHAR_LOWER_A : CHAR_UPPER_A)
                            + 8'($urandom_range(25, 0));
            1:       return 8'($urandom_range(255, 0));
            default: return EDGE_BYTES[$urandom_range(9, 0)];
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [63:0] value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_PATTERN_LOW:    pattern_q[63:0] = value;
            REG_PATTERN_HIGH:   pattern_q[127:64] = value;
            REG_PATTERN_LEN:    len_q = value[LEN_W-1:0];
            REG_CASE_SENSITIVE: exact_q = value[0];
            default:            ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic send_byte(input logic [7:0] value, input logic last, input check_t chk,
                             input logic t_found, input logic [OFFSET_W-1:0] t_offset);
        int     gap;
        bit     has;
        match_t res;
        gap = $urandom_range(tx_max_gap, 0);
        if (gap > 0)
        begin
            byte_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        byte_valid = 1'b1;
        buffer_byte = value;
        last_byte = last;
        do @(posedge clk); while (byte_stall);
        advance_search(value, last, has, res);
        if (chk == CHK_MODEL && has)
        begin
            pending_matches.push_back(res);
        end
        else if (chk == CHK_RESULT)
        begin
            res.found = t_found;
            res.offset = t_offset;
            pending_matches.push_back(res);
        end
        @(negedge clk);
    endtask

    // drain all results, then give the pipeline time to empty
    task automatic settle();
        byte_valid = 1'b0;
        while (pending_matches.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        int hold;
        result_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (pressure_req)
            begin
                result_stall = 1'b1;
                repeat (PRESSURE_CYCLES) @(negedge clk);
                pressure_req = 1'b0;
            end
            hold = $urandom_range(rx_max_stall, 0);
            if (hold > 0)
            begin
                result_stall = 1'b1;
                repeat (hold) @(negedge clk);
            end
            result_stall = 1'b0;
            do @(posedge clk); while (!result_valid);
        end
    end

    always @(posedge clk)
    begin
        match_t want;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (pending_matches.size() == 0)
                begin
                    report_mismatch($sformatf("word found=%0b offset=%0d with none pending",
                                              found, match_offset));
                end
                else
                begin
                    want = pending_matches.pop_front();
                    if (found !== want.found)
                    begin
                        report_mismatch($sformatf("found %0b, want %0b", found, want.found));
                    end
                    if (match_offset !== want.offset)
                    begin
                        report_mismatch($sformatf("match_offset %0d, want %0d",
                                                  match_offset, want.offset));
                    end
                end
            end
            if ((byte_valid && !byte_stall) || (result_valid && !result_stall) ||
                (cfg_valid && cfg_ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT)
                begin
                    $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
                    $display("== FAIL ==");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        logic [7:0]   frame_bytes [$];
        logic [127:0] pat_bits;
        logic [7:0]   p;
        int           eff;
        int           frame_len;
        int           pos;
        int           sent;
        int           phase;
        int           phase_items;
        int           pick_len;
        logic         pick_exact;

        rst_n = 1'b0;
        byte_valid = 1'b0;
        buffer_byte = 8'h00;
        last_byte = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_PATTERN_LOW;
        cfg_data = '0;
        tx_max_gap = 0;
        rx_max_stall = 0;
        pressure_req = 1'b0;
        mismatch_count = 0;
        quiet_cycles = 0;
        pattern_q = '0;
        len_q = LEN_W'(1);
        exact_q = 1'b1;
        clear_search();

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        tx_max_gap = 3;
        rx_max_stall = 3;
        foreach (DIRECTED[i])
        begin
            if (DIRECTED[i].kind == ROW_CFG)
            begin
                settle();
                write_reg(DIRECTED[i].idx, DIRECTED[i].data);
            end
            else
            begin
                send_byte(DIRECTED[i].value, DIRECTED[i].last, DIRECTED[i].chk,
                          DIRECTED[i].t_found, DIRECTED[i].t_offset);
            end
        end

        sent = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            settle();
            for (int k = 0; k < PATTERN_BYTES; k++)
            begin
                pat_bits[8*k +: 8] = pattern_pick();
            end
            case (phase)
                0:       pick_len = 16;
                1:       pick_len = 31;
                2:       pick_len = 1;
                3:       pick_len = 0;
                default: pick_len = ($urandom_range(1, 0) == 1) ? $urandom_range(6, 0)
                                                               : $urandom_range(31, 0);
            endcase
            if (phase == 2)
            begin
                pat_bits = '0;
            end
            if (phase == 3)
            begin
                pat_bits = '1;
            end
            pick_exact = (phase < 4) ? phase[0] : 1'($urandom_range(1, 0));
            write_reg(REG_PATTERN_LOW, pat_bits[63:0]);
            write_reg(REG_PATTERN_HIGH, pat_bits[127:64]);
            write_reg(REG_PATTERN_LEN, 64'(pick_len));
            write_reg(REG_CASE_SENSITIVE, 64'(pick_exact));

            tx_max_gap = (phase % 4 == 1 || phase == 6) ? 0 : 3;
            rx_max_stall = (phase % 3 == 2) ? 0 : 3;
            if (phase == 6)
            begin
                pressure_req = 1'b1;
            end

            eff = active_pattern_len();
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
            begin
                frame_len = ($urandom_range(4, 0) == 0) ? $urandom_range(eff, 1)
                                                        : eff + $urandom_range(24, 0);
                frame_bytes.delete();
                for (int k = 0; k < frame_len; k++)
                begin
                    frame_bytes.push_back(filler_byte(eff));
                end
                if ($urandom_range(3, 0) != 0 && frame_len >= eff)
                begin
                    pos = $urandom_range(frame_len - eff, 0);
                    for (int k = 0; k < eff; k++)
                    begin
                        p = pattern_q[8*k +: 8];
                        if ($urandom_range(exact_q ? 7 : 1, 0) == 0)
                        begin
                            p = flip_case(p);
                        end
                        frame_bytes[pos + k] = p;
                    end
                    // break the embedded copy now and then
                    if ($urandom_range(5, 0) == 0)
                    begin
                        frame_bytes[pos + $urandom_range(eff - 1, 0)] =
                            8'($urandom_range(255, 0));
                    end
                end
                foreach (frame_bytes[k])
                begin
                    send_byte(frame_bytes[k], k == frame_len - 1, CHK_MODEL, 1'b0, '0);
                end
                phase_items += frame_len;
            end
            sent += phase_items;
            phase++;
        end

        byte_valid = 1'b0;
        while (pending_matches.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
